/* rtl/macd_indicator_core_assert.svh */
// Assertion macros for the checker of the indicator core.
`ifndef MACD_INDICATOR_CORE_ASSERT_SVH
`define MACD_INDICATOR_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MACD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("macd_indicator_core check failed");

// The consequent holds in the cycle after the antecedent.
`define MACD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("macd_indicator_core check failed");

`endif

/* rtl/macd_pkg.sv */
package macd_pkg;

    localparam int PRICE_W       = 32;
    localparam int AVG_W         = 48;
    localparam int DIFF_W        = 49;
    localparam int BAR_W         = 51;
    localparam int PER_W         = 8;
    localparam int DVS_W         = PER_W + 1;
    localparam int DVD_W         = AVG_W + DVS_W;
    localparam int NUM_W         = DVD_W + 1;
    localparam int CFG_IDX_W     = 2;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [PER_W-1:0] FAST_PER_RST   = 8'd12;
    localparam logic [PER_W-1:0] SLOW_PER_RST   = 8'd26;
    localparam logic [PER_W-1:0] SIGNAL_PER_RST = 8'd9;

    localparam logic [CFG_IDX_W-1:0] REG_FAST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL = 2'd2;

    typedef struct packed {
        logic load;
        logic seed;
        logic form_price;
        logic start_price;
        logic take_price;
        logic form_signal;
        logic start_signal;
        logic take_signal;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic div_done;
        logic out_busy;
    } t_dp_stat;

    // A period of zero behaves as a period of one.
    function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p);
        return (p == '0) ? PER_W'(1) : p;
    endfunction

    function automatic logic [DVS_W-1:0] period_divisor(input logic [PER_W-1:0] p);
        return {1'b0, eff_period(p)} + DVS_W'(1);
    endfunction

endpackage

/* rtl/macd_div.sv */
module macd_div #(
    parameter int QW = macd_pkg::AVG_W,
    parameter int DW = macd_pkg::DVS_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [QW+DW-1:0] i_dividend,
    input  logic [DW-1:0]   i_divisor,
    output logic            o_done,
    output logic [QW-1:0]   o_quotient
);
    localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;
    logic [DW-1:0]    r_dvs;
    logic [DW:0]      w_trial;
    logic             w_ge;
    logic [DW:0]      w_diff;

    // The upper dividend bits are known to stay below the divisor, so only
    // the quotient bits need an iteration each.
    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[QW+DW-1:QW];
            r_quo <= i_dividend[QW-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/macd_dp.sv */
module macd_dp #(
    parameter int FRAC_BITS = macd_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  macd_pkg::t_dp_cmd                 i_cmd,
    output macd_pkg::t_dp_stat                o_stat,
    input  logic                              i_cfg_valid,
    input  logic [macd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [macd_pkg::PER_W-1:0]        i_cfg_data,
    input  logic [macd_pkg::PRICE_W-1:0]      i_close_price,
    input  logic                              i_first_sample,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [macd_pkg::AVG_W-1:0]        o_fast_average,
    output logic [macd_pkg::AVG_W-1:0]        o_slow_average,
    output logic signed [macd_pkg::DIFF_W-1:0] o_diff_line,
    output logic signed [macd_pkg::DIFF_W-1:0] o_dea_line,
    output logic signed [macd_pkg::BAR_W-1:0] o_macd_bar
);
    import macd_pkg::*;

    localparam int EXT_W = (PRICE_W + FRAC_BITS > AVG_W) ? PRICE_W + FRAC_BITS : AVG_W;

    logic [PER_W-1:0]  r_per_fast;
    logic [PER_W-1:0]  r_per_slow;
    logic [PER_W-1:0]  r_per_sig;
    logic [AVG_W-1:0]  r_fast;
    logic [AVG_W-1:0]  r_slow;
    logic [DIFF_W-1:0] r_sig;
    logic [DIFF_W-1:0] r_diff;
    logic [AVG_W-1:0]  r_x;
    logic              r_first;
    logic [NUM_W-1:0]  r_num_a;
    logic [NUM_W-1:0]  r_num_b;
    logic [DVS_W-1:0]  r_dvs_a;
    logic [DVS_W-1:0]  r_dvs_b;
    logic              r_out_valid;
    logic [AVG_W-1:0]  r_out_fast;
    logic [AVG_W-1:0]  r_out_slow;
    logic [DIFF_W-1:0] r_out_diff;
    logic [DIFF_W-1:0] r_out_dea;
    logic [BAR_W-1:0]  r_out_bar;

    logic [EXT_W-1:0]          w_shifted;
    logic [AVG_W-1:0]          w_scaled;
    logic [PER_W-1:0]          w_kf_m1;
    logic [PER_W-1:0]          w_ks_m1;
    logic [PER_W-1:0]          w_kg_m1;
    logic [AVG_W+PER_W-1:0]    w_prod_fast;
    logic [AVG_W+PER_W-1:0]    w_prod_slow;
    logic signed [NUM_W-1:0]   w_prod_sig;
    logic [NUM_W-1:0]          w_num_fast;
    logic [NUM_W-1:0]          w_num_slow;
    logic [NUM_W-1:0]          w_num_sig;
    logic [NUM_W-1:0]          w_mag_a;
    logic                      w_done_a;
    logic [AVG_W-1:0]          w_q_a;
    logic [AVG_W-1:0]          w_q_b;
    logic [DIFF_W-1:0]         w_q_signed;
    logic [DIFF_W:0]           w_gap;

    // Prices beyond the average width saturate.
    assign w_shifted = EXT_W'(i_close_price) << FRAC_BITS;
    assign w_scaled  = ((w_shifted >> AVG_W) != '0) ? '1 : w_shifted[AVG_W-1:0];

    assign w_kf_m1 = eff_period(r_per_fast) - PER_W'(1);
    assign w_ks_m1 = eff_period(r_per_slow) - PER_W'(1);
    assign w_kg_m1 = eff_period(r_per_sig) - PER_W'(1);

    assign w_prod_fast = w_kf_m1 * r_fast;
    assign w_prod_slow = w_ks_m1 * r_slow;
    assign w_prod_sig  = $signed({1'b0, w_kg_m1}) * $signed(r_sig);

    assign w_num_fast = {{(NUM_W-AVG_W-1){1'b0}}, r_x, 1'b0}
                      + {{(NUM_W-AVG_W-PER_W){1'b0}}, w_prod_fast};
    assign w_num_slow = {{(NUM_W-AVG_W-1){1'b0}}, r_x, 1'b0}
                      + {{(NUM_W-AVG_W-PER_W){1'b0}}, w_prod_slow};
    assign w_num_sig  = {{(NUM_W-DIFF_W-1){r_diff[DIFF_W-1]}}, r_diff, 1'b0}
                      + w_prod_sig;

    // Signed division runs on the magnitude and truncates toward zero.
    assign w_mag_a    = r_num_a[NUM_W-1] ? (-r_num_a) : r_num_a;
    assign w_q_signed = r_num_a[NUM_W-1] ? (-{1'b0, w_q_a}) : {1'b0, w_q_a};

    assign w_gap = {r_diff[DIFF_W-1], r_diff} - {r_sig[DIFF_W-1], r_sig};

    macd_div #(
        .QW(AVG_W),
        .DW(DVS_W)
    ) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_price | i_cmd.start_signal),
        .i_dividend (w_mag_a[DVD_W-1:0]),
        .i_divisor  (r_dvs_a),
        .o_done     (w_done_a),
        .o_quotient (w_q_a)
    );

    macd_div #(
        .QW(AVG_W),
        .DW(DVS_W)
    ) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_price),
        .i_dividend (r_num_b[DVD_W-1:0]),
        .i_divisor  (r_dvs_b),
        .o_done     (),
        .o_quotient (w_q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_fast  <= FAST_PER_RST;
            r_per_slow  <= SLOW_PER_RST;
            r_per_sig   <= SIGNAL_PER_RST;
            r_fast      <= '0;
            r_slow      <= '0;
            r_sig       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FAST:   r_per_fast <= i_cfg_data;
                    REG_SLOW:   r_per_slow <= i_cfg_data;
                    REG_SIGNAL: r_per_sig  <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_cmd.seed) begin
                r_fast <= r_x;
                r_slow <= r_x;
                r_sig  <= '0;
            end else if (i_cmd.take_price) begin
                r_fast <= w_q_a;
                r_slow <= w_q_b;
            end else if (i_cmd.take_signal) begin
                r_sig <= w_q_signed;
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= w_scaled;
            r_first <= i_first_sample;
        end
        if (i_cmd.seed) begin
            r_diff <= '0;
        end else if (i_cmd.take_price) begin
            r_diff <= {1'b0, w_q_a} - {1'b0, w_q_b};
        end
        if (i_cmd.form_price) begin
            r_num_a <= w_num_fast;
            r_num_b <= w_num_slow;
            r_dvs_a <= period_divisor(r_per_fast);
            r_dvs_b <= period_divisor(r_per_slow);
        end else if (i_cmd.form_signal) begin
            r_num_a <= w_num_sig;
            r_dvs_a <= period_divisor(r_per_sig);
        end
        if (i_cmd.publish) begin
            r_out_fast <= r_fast;
            r_out_slow <= r_slow;
            r_out_diff <= r_diff;
            r_out_dea  <= r_sig;
            r_out_bar  <= {w_gap, 1'b0};
        end
    end

    assign o_stat.first    = r_first;
    assign o_stat.div_done = w_done_a;
    assign o_stat.out_busy = r_out_valid & ~i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_fast_average = r_out_fast;
    assign o_slow_average = r_out_slow;
    assign o_diff_line    = r_out_diff;
    assign o_dea_line     = r_out_dea;
    assign o_macd_bar     = r_out_bar;

endmodule

/* rtl/macd_ctrl.sv */
module macd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  macd_pkg::t_dp_stat i_stat,
    output macd_pkg::t_dp_cmd  o_cmd
);
    import macd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_START_PRICE,
        S_WAIT_PRICE,
        S_PREP_SIG,
        S_START_SIG,
        S_WAIT_SIG,
        S_OUT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                if (i_stat.first) begin
                    w_cmd.seed = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    w_cmd.form_price = 1'b1;
                    n_state          = S_START_PRICE;
                end
            end
            S_START_PRICE: begin
                w_cmd.start_price = 1'b1;
                n_state           = S_WAIT_PRICE;
            end
            S_WAIT_PRICE: begin
                if (i_stat.div_done) begin
                    w_cmd.take_price = 1'b1;
                    n_state          = S_PREP_SIG;
                end
            end
            S_PREP_SIG: begin
                w_cmd.form_signal = 1'b1;
                n_state           = S_START_SIG;
            end
            S_START_SIG: begin
                w_cmd.start_signal = 1'b1;
                n_state            = S_WAIT_SIG;
            end
            S_WAIT_SIG: begin
                if (i_stat.div_done) begin
                    w_cmd.take_signal = 1'b1;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    w_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

/* rtl/macd_indicator_core.sv */
// MACD indicator core. Each accepted word carries one close price; every word
// returns one result word with the fast and slow exponential averages, their
// difference, its signal average and the bar value, all in fixed point with
// FRAC_BITS fraction bits. A word marked as first sample reseeds the averages
// without a division; any other word goes through two radix-2 dividers that
// each resolve one quotient bit per cycle: fast and slow averages divide in
// parallel, then the signal average divides on the fast average's unit. Both
// kinds of word hold off the next ready while the output register still holds
// a result that has not been taken. The period registers may be written at any
// time the block is idle.
module macd_indicator_core #(
    parameter int FRAC_BITS = macd_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [macd_pkg::PRICE_W-1:0]       i_close_price,
    input  logic                               i_first_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [macd_pkg::AVG_W-1:0]         o_fast_average,
    output logic [macd_pkg::AVG_W-1:0]         o_slow_average,
    output logic signed [macd_pkg::DIFF_W-1:0] o_diff_line,
    output logic signed [macd_pkg::DIFF_W-1:0] o_dea_line,
    output logic signed [macd_pkg::BAR_W-1:0]  o_macd_bar,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [macd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [macd_pkg::PER_W-1:0]         i_cfg_data
);
    import macd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    macd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    macd_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_close_price  (i_close_price),
        .i_first_sample (i_first_sample),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_fast_average (o_fast_average),
        .o_slow_average (o_slow_average),
        .o_diff_line    (o_diff_line),
        .o_dea_line     (o_dea_line),
        .o_macd_bar     (o_macd_bar)
    );

    assign o_cfg_ready = 1'b1;

endmodule

/* rtl/macd_checker.sv */
`include "macd_indicator_core_assert.svh"

module macd_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_first_sample,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [macd_pkg::AVG_W-1:0]         o_fast_average,
    input logic [macd_pkg::AVG_W-1:0]         o_slow_average,
    input logic signed [macd_pkg::DIFF_W-1:0] o_diff_line,
    input logic signed [macd_pkg::DIFF_W-1:0] o_dea_line,
    input logic signed [macd_pkg::BAR_W-1:0]  o_macd_bar
);
    import macd_pkg::*;

    logic              w_in_acc;
    logic              w_seed_acc;
    logic [DIFF_W-1:0] w_diff_exp;
    logic [DIFF_W:0]   w_gap;
    logic [BAR_W-1:0]  w_bar_exp;
    logic              w_seed_word;

    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_seed_acc  = w_in_acc & i_first_sample & ~o_out_valid;
    assign w_diff_exp  = {1'b0, o_fast_average} - {1'b0, o_slow_average};
    assign w_gap       = {o_diff_line[DIFF_W-1], o_diff_line}
                       - {o_dea_line[DIFF_W-1], o_dea_line};
    assign w_bar_exp   = {w_gap, 1'b0};
    assign w_seed_word = o_out_valid && (o_fast_average == o_slow_average)
                       && (o_diff_line == '0) && (o_dea_line == '0)
                       && (o_macd_bar == '0);

    `MACD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `MACD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_in_ready)
    `MACD_ASSERT_NOW(a_diff_match, i_clk, i_rst_n, o_out_valid, o_diff_line == w_diff_exp)
    `MACD_ASSERT_NOW(a_bar_match, i_clk, i_rst_n, o_out_valid, o_macd_bar == w_bar_exp)
    `MACD_ASSERT_NOW(a_seed_result, i_clk, i_rst_n, w_seed_acc, ##3 w_seed_word)

endmodule

bind macd_indicator_core macd_checker u_macd_checker (.*);

/* tb/tb.sv */
module tb;
    import macd_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES = 17;
    localparam longint unsigned AVG_MAX = (64'd1 << AVG_W) - 64'd1;

    typedef struct {
        logic [AVG_W-1:0]  fast;
        logic [AVG_W-1:0]  slow;
        logic [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0] dea;
        logic [BAR_W-1:0]  bar;
    } t_macd_word;

    class macd_scoreboard;
        logic [PER_W-1:0] fast_per;
        logic [PER_W-1:0] slow_per;
        logic [PER_W-1:0] signal_per;
        longint unsigned  fast_avg;
        longint unsigned  slow_avg;
        longint           signal_avg;
        t_macd_word       pending_words[$];
        int               mismatches;

        function new();
            fast_per   = FAST_PER_RST;
            slow_per   = SLOW_PER_RST;
            signal_per = SIGNAL_PER_RST;
            fast_avg   = 0;
            slow_avg   = 0;
            signal_avg = 0;
            mismatches = 0;
        endfunction

        function void write_period(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [PER_W-1:0] val);
            case (idx)
                REG_FAST:   fast_per = val;
                REG_SLOW:   slow_per = val;
                REG_SIGNAL: signal_per = val;
                default: ;
            endcase
        endfunction

        function longint period_of(input logic [PER_W-1:0] p);
            return (p == '0) ? 64'sd1 : longint'(p);
        endfunction

        function void note_word(input logic [PRICE_W-1:0] price, input logic first);
            longint unsigned x;
            longint unsigned ku;
            longint          ks;
            longint          diff;
            longint          bar;
            t_macd_word      w;
            if (FRAC > 16 && {32'd0, price} > (AVG_MAX >> FRAC)) begin
                x = AVG_MAX;
            end else begin
                x = ({32'd0, price} << FRAC) & AVG_MAX;
            end
            if (first) begin
                fast_avg   = x;
                slow_avg   = x;
                signal_avg = 0;
                diff       = 0;
            end else begin
                ku = period_of(fast_per);
                fast_avg = ((2 * x + (ku - 1) * fast_avg) / (ku + 1)) & AVG_MAX;
                ku = period_of(slow_per);
                slow_avg = ((2 * x + (ku - 1) * slow_avg) / (ku + 1)) & AVG_MAX;
                diff = longint'(fast_avg) - longint'(slow_avg);
                ks = period_of(signal_per);
                signal_avg = (2 * diff + (ks - 1) * signal_avg) / (ks + 1);
            end
            bar = 2 * (diff - signal_avg);
            w.fast = fast_avg[AVG_W-1:0];
            w.slow = slow_avg[AVG_W-1:0];
            w.diff = diff[DIFF_W-1:0];
            w.dea  = signal_avg[DIFF_W-1:0];
            w.bar  = bar[BAR_W-1:0];
            pending_words.insert(pending_words.size(), w);
        endfunction

        function void check_word(input logic [AVG_W-1:0] fast, input logic [AVG_W-1:0] slow,
                                 input logic [DIFF_W-1:0] diff, input logic [DIFF_W-1:0] dea,
                                 input logic [BAR_W-1:0] bar);
            t_macd_word w;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: fast %h slow %h diff %h dea %h bar %h",
                             fast, slow, diff, dea, bar);
                end
                return;
            end
            w = pending_words[0];
            pending_words.delete(0);
            if (fast !== w.fast || slow !== w.slow || diff !== w.diff || dea !== w.dea
                    || bar !== w.bar) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected fast %h slow %h diff %h dea %h bar %h",
                             w.fast, w.slow, w.diff, w.dea, w.bar);
                    $display("                 actual   fast %h slow %h diff %h dea %h bar %h",
                             fast, slow, diff, dea, bar);
                end
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [PRICE_W-1:0]          i_close_price;
    logic                        i_first_sample;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [AVG_W-1:0]            o_fast_average;
    logic [AVG_W-1:0]            o_slow_average;
    logic signed [DIFF_W-1:0]    o_diff_line;
    logic signed [DIFF_W-1:0]    o_dea_line;
    logic signed [BAR_W-1:0]     o_macd_bar;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [PER_W-1:0]            i_cfg_data;

    macd_scoreboard sb;
    int quiet_cycles = 0;
    int burst_left = 0;
    int rx_left = 0;
    bit rx_random = 1'b0;
    bit rx_level = 1'b1;
    int rx_pick;

    macd_indicator_core #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_close_price(i_close_price),
        .i_first_sample(i_first_sample),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_fast_average(o_fast_average),
        .o_slow_average(o_slow_average),
        .o_diff_line(o_diff_line),
        .o_dea_line(o_dea_line),
        .o_macd_bar(o_macd_bar),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_pick = $urandom_range(0, 7);
            if (rx_pick == 0) begin
                rx_random = 1'b0;
                rx_level  = 1'b1;
                rx_left   = $urandom_range(100, 400);
            end else if (rx_pick == 1) begin
                rx_random = 1'b0;
                rx_level  = 1'b0;
                rx_left   = $urandom_range(1, 40);
            end else begin
                rx_random = 1'b1;
                rx_left   = $urandom_range(1, 60);
            end
        end
        rx_left--;
        i_out_ready <= rx_random ? 1'($urandom_range(0, 1)) : rx_level;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_word(o_fast_average, o_slow_average, o_diff_line, o_dea_line,
                              o_macd_bar);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_word(i_close_price, i_first_sample);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_period(i_cfg_index, i_cfg_data);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_word(input logic [PRICE_W-1:0] price, input logic first);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 130)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_close_price  <= price;
        i_first_sample <= first;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic program_periods(input logic [PER_W-1:0] fast_n,
                                   input logic [PER_W-1:0] slow_n,
                                   input logic [PER_W-1:0] signal_n);
        logic [CFG_IDX_W-1:0] regs [3];
        logic [PER_W-1:0]     vals [3];
        regs = '{REG_FAST, REG_SLOW, REG_SIGNAL};
        vals = '{fast_n, slow_n, signal_n};
        wait_idle();
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [PER_W-1:0] pick_period();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return PER_W'(1);
            2: return '1;
            default: return PER_W'($urandom_range(2, 254));
        endcase
    endfunction

    function automatic longint pick_base();
        case ($urandom_range(0, 3))
            0: return longint'($urandom_range(0, 1000));
            1: return longint'($urandom);
            2: return 64'hFFFF_FFFF - longint'($urandom_range(0, 100000));
            default: return longint'($urandom_range(1000, 100000));
        endcase
    endfunction

    initial begin
        int                 n;
        int                 r;
        longint             walk;
        longint             span;
        logic [PRICE_W-1:0] p;
        logic               f;

        sb = new();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_close_price  <= '0;
        i_first_sample <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_FAST;
        i_cfg_data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Averages start from zero when no first sample has been seen yet.
        send_word(32'd1000, 1'b0);
        send_word('1, 1'b1);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word('0, 1'b0);
        send_word('1, 1'b0);
        send_word('0, 1'b1);
        send_word(32'h8000_0000, 1'b0);

        // A period of zero behaves as a period of one.
        program_periods('0, '0, '0);
        send_word(32'd5000, 1'b1);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word(32'h5555_5555, 1'b0);

        program_periods('1, '1, '1);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word('1, 1'b0);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word('0, 1'b0);

        program_periods(PER_W'(1), '1, PER_W'(1));
        send_word(32'd123, 1'b1);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word(32'd777, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            program_periods(pick_period(), pick_period(), pick_period());
            n    = $urandom_range(80, 120);
            span = 64'sd1 << $urandom_range(0, 20);
            walk = pick_base();
            send_word(walk[PRICE_W-1:0], 1'b1);
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    p = $urandom;
                    f = 1'($urandom_range(0, 1));
                end else if (r == 1) begin
                    walk = pick_base();
                    p = walk[PRICE_W-1:0];
                    f = 1'b1;
                end else begin
                    walk = walk + longint'($urandom_range(0, 32'(2 * span))) - span;
                    if (walk < 0) walk = 0;
                    if (walk > 64'hFFFF_FFFF) walk = 64'hFFFF_FFFF;
                    p = walk[PRICE_W-1:0];
                    f = 1'b0;
                end
                if (ph == 5 && k == 50) begin
                    wait_idle();
                end
                send_word(p, f);
            end
        end

        wait_idle();
        repeat (110) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
